FILE: rtl/polygon_plane_clipper_defines.svh
// ---------------------------------------------------------------------------
// Polygon plane clipper assertion macros
// Shared concurrent assertion forms for the clipper RTL.
// ---------------------------------------------------------------------------
`ifndef POLYGON_PLANE_CLIPPER_DEFINES_SVH
`define POLYGON_PLANE_CLIPPER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define PPC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// A trigger that must be followed by a consequence in the next cycle.
`define PPC_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("next-cycle check violated");

`endif

FILE: rtl/ppc_pkg.sv
// ---------------------------------------------------------------------------
// Polygon plane clipper package
// Types, codes and fixed widths shared by the clipper and its interfaces.
// ---------------------------------------------------------------------------
package ppc_pkg;

   // Coordinate and distance width.
   localparam int COORD_W   = 16;
   localparam int NUM_AXES  = 3;
   localparam int AXIS_W    = 2;

   // Results of one input item are collected before they are sent.
   localparam int BUF_DEPTH = 4;
   localparam int BUF_IDX_W = 2;
   localparam int BUF_CNT_W = 3;

   // Emitted vertex count of a polygon saturates here.
   localparam int COUNT_W   = 6;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

   localparam int COORD_MAX = 32767;
   localparam int COORD_MIN = -32768;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_COUNT = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_D  = 2'd3;
   localparam logic [COORD_W-1:0]   NORMAL_Z_RESET = 16'h7FFF;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [NUM_AXES-1:0][COORD_W-1:0] vec_type;

   // One collected result: a vertex or a bare end marker.
   typedef struct packed {
      logic    has_vertex;
      vec_type vert;
   } item_type;

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_DOT_MUL   = 11'b000_0000_0010,
      ST_DOT_ACC   = 11'b000_0000_0100,
      ST_DIST      = 11'b000_0000_1000,
      ST_EDGE_SEL  = 11'b000_0001_0000,
      ST_EDGE_TEST = 11'b000_0010_0000,
      ST_DIV       = 11'b000_0100_0000,
      ST_PT_MUL    = 11'b000_1000_0000,
      ST_PT_ADD    = 11'b001_0000_0000,
      ST_FINISH    = 11'b010_0000_0000,
      ST_SEND      = 11'b100_0000_0000
   } state_type;

endpackage

FILE: rtl/ppc_req_if.sv
// ---------------------------------------------------------------------------
// Polygon plane clipper vertex channel
// Valid/ready channel that carries one input vertex per item.
// ---------------------------------------------------------------------------
interface ppc_req_if import ppc_pkg::*; ();

   logic      valid;
   logic      ready;
   coord_type vert_x;
   coord_type vert_y;
   coord_type vert_z;
   logic      last_vertex;

   modport source (output valid, output vert_x, output vert_y, output vert_z,
                   output last_vertex, input ready);
   modport sink   (input valid, input vert_x, input vert_y, input vert_z,
                   input last_vertex, output ready);

endinterface

FILE: rtl/ppc_rsp_if.sv
// ---------------------------------------------------------------------------
// Polygon plane clipper result channel
// Valid/ready channel that carries one clipped vertex or end marker per item.
// ---------------------------------------------------------------------------
interface ppc_rsp_if import ppc_pkg::*; ();

   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      has_vertex;
   logic      polygon_end;
   logic      polygon_kept;

   modport source (output valid, output out_x, output out_y, output out_z,
                   output has_vertex, output polygon_end, output polygon_kept,
                   input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z,
                   input has_vertex, input polygon_end, input polygon_kept,
                   output ready);

endinterface

FILE: rtl/polygon_plane_clipper.sv
// ---------------------------------------------------------------------------
// Polygon plane clipper
// Clips a streamed polygon against one plane, one edge at a time, with a
// single shared multiplier and a serial divider under a small sequencer.
// ---------------------------------------------------------------------------
//   Channel   Direction   Handshake      Carries
//   req_ch    in          valid/ready    vertex x/y/z, last_vertex flag
//   rsp_ch    out         valid/ready    vertex x/y/z, has_vertex, end, kept
//   csr_*     in          write enable   normal_x/y/z and plane_d
//
// Each item runs a three-step dot product on the shared multiplier, tests each
// edge it closes (0 to 2), runs the one-bit-per-cycle divider for t at each
// plane crossing and then sends the results it has collected.
// The block takes no new item until every result of the current one has left.
// A stalled result channel simply holds the sequencer in its send step.
// Reset is synchronous and returns the block to waiting for a first vertex.
// ---------------------------------------------------------------------------
`include "polygon_plane_clipper_defines.svh"

module polygon_plane_clipper import ppc_pkg::*; #(
   parameter int NORMAL_SHIFT = 15,
   parameter int T_FRAC_BITS  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   ppc_req_if.sink              req_ch,
   ppc_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   // Derived widths of the datapath.
   localparam int T_W       = T_FRAC_BITS + 1;
   localparam int MUL_A_W   = COORD_W + 1;
   localparam int MUL_B_W   = (T_FRAC_BITS + 2 > COORD_W) ? T_FRAC_BITS + 2 : COORD_W;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int REM_W     = COORD_W + 1;
   localparam int DIV_CNT_W = $clog2(T_FRAC_BITS + 1);

   localparam logic signed [ACC_W-1:0] DIST_MAX = ACC_W'(COORD_MAX);
   localparam logic signed [ACC_W-1:0] DIST_MIN = ACC_W'(COORD_MIN);

   state_type                  state_ff, state_in;
   logic [COORD_W-1:0]         cfg_ff [CSR_COUNT];
   vec_type                    cur_v_ff, cur_v_in;
   logic                       last_ff, last_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [AXIS_W-1:0]          axis_ff, axis_in;
   coord_type                  cur_d_ff, cur_d_in;
   vec_type                    first_v_ff, first_v_in;
   coord_type                  first_d_ff, first_d_in;
   vec_type                    prev_v_ff, prev_v_in;
   coord_type                  prev_d_ff, prev_d_in;
   logic                       have_first_ff, have_first_in;
   logic                       edge0_ff, edge0_in;
   logic                       edge1_ff, edge1_in;
   vec_type                    s_v_ff, s_v_in;
   coord_type                  s_d_ff, s_d_in;
   vec_type                    e_v_ff, e_v_in;
   coord_type                  e_d_ff, e_d_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [REM_W-1:0]           den_ff, den_in;
   logic [T_W-1:0]             t_ff, t_in;
   logic [DIV_CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   vec_type                    pt_v_ff, pt_v_in;
   item_type                   buf_ff [BUF_DEPTH];
   item_type                   buf_in [BUF_DEPTH];
   logic [BUF_CNT_W-1:0]       buf_cnt_ff, buf_cnt_in;
   logic [BUF_IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic                       kept_ff, kept_in;

   // Datapath helpers.
   coord_type                  plane_d;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [ACC_W-1:0]    dot_sh;
   coord_type                  dist_sat;
   coord_type                  sel_s;
   coord_type                  sel_e;
   logic signed [MUL_A_W-1:0]  delta;
   logic signed [MUL_A_W-1:0]  num_diff;
   logic signed [MUL_A_W-1:0]  den_diff;
   logic signed [PROD_W-1:0]   pt_off;
   logic                       s_in_side;
   logic                       e_in_side;
   logic                       div_ge;
   logic [REM_W-1:0]           rem_sub;
   logic                       send_last;
   item_type                   send_item;

   assign plane_d = $signed(cfg_ff[CSR_PLANE_D]);
   assign sel_s   = $signed(s_v_ff[axis_ff]);
   assign sel_e   = $signed(e_v_ff[axis_ff]);
   assign delta   = MUL_A_W'(sel_e) - MUL_A_W'(sel_s);

   // Plane distance: floor shift of the dot product, then saturation.
   assign dot_sh   = acc_ff >>> NORMAL_SHIFT;
   assign dist_sat = (dot_sh > DIST_MAX) ? coord_type'(COORD_MAX) :
                     (dot_sh < DIST_MIN) ? coord_type'(COORD_MIN) :
                     coord_type'(dot_sh[COORD_W-1:0]);

   // Inside tests and the magnitudes that feed the divider.
   assign s_in_side = s_d_ff >= plane_d;
   assign e_in_side = e_d_ff >= plane_d;
   assign num_diff  = MUL_A_W'(plane_d) - MUL_A_W'(s_d_ff);
   assign den_diff  = MUL_A_W'(e_d_ff) - MUL_A_W'(s_d_ff);

   // One restoring division step.
   assign div_ge  = rem_ff >= den_ff;
   assign rem_sub = div_ge ? (rem_ff - den_ff) : rem_ff;

   assign pt_off = prod_ff >>> T_FRAC_BITS;

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_DOT_MUL) begin
         mul_a = MUL_A_W'($signed(cur_v_ff[axis_ff]));
         mul_b = MUL_B_W'($signed(cfg_ff[axis_ff]));
      end else if (state_ff == ST_PT_MUL) begin
         mul_a = delta;
         mul_b = $signed(MUL_B_W'(t_ff));
      end
   end

   // Result channel is driven straight from the collected items.
   assign send_item = buf_ff[rd_idx_ff];
   assign send_last = (BUF_CNT_W'(BUF_CNT_W'(rd_idx_ff) + BUF_CNT_W'(1)) == buf_cnt_ff);

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = (state_ff == ST_SEND);
   assign rsp_ch.out_x        = $signed(send_item.vert[0]);
   assign rsp_ch.out_y        = $signed(send_item.vert[1]);
   assign rsp_ch.out_z        = $signed(send_item.vert[2]);
   assign rsp_ch.has_vertex   = send_item.has_vertex;
   assign rsp_ch.polygon_end  = last_ff && send_last;
   assign rsp_ch.polygon_kept = last_ff && send_last && kept_ff;

   // Sequencer and next-state datapath.
   always_comb begin
      state_in      = state_ff;
      cur_v_in      = cur_v_ff;
      last_in       = last_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      axis_in       = axis_ff;
      cur_d_in      = cur_d_ff;
      first_v_in    = first_v_ff;
      first_d_in    = first_d_ff;
      prev_v_in     = prev_v_ff;
      prev_d_in     = prev_d_ff;
      have_first_in = have_first_ff;
      edge0_in      = edge0_ff;
      edge1_in      = edge1_ff;
      s_v_in        = s_v_ff;
      s_d_in        = s_d_ff;
      e_v_in        = e_v_ff;
      e_d_in        = e_d_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      t_in          = t_ff;
      div_cnt_in    = div_cnt_ff;
      pt_v_in       = pt_v_ff;
      buf_in        = buf_ff;
      buf_cnt_in    = buf_cnt_ff;
      rd_idx_in     = rd_idx_ff;
      count_in      = count_ff;
      kept_in       = kept_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cur_v_in[0] = req_ch.vert_x;
               cur_v_in[1] = req_ch.vert_y;
               cur_v_in[2] = req_ch.vert_z;
               last_in     = req_ch.last_vertex;
               acc_in      = '0;
               axis_in     = '0;
               buf_cnt_in  = '0;
               rd_idx_in   = '0;
               state_in    = ST_DOT_MUL;
            end
         end

         ST_DOT_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_DOT_ACC;
         end

         ST_DOT_ACC: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            if (axis_ff == AXIS_W'(NUM_AXES - 1)) begin
               state_in = ST_DIST;
            end else begin
               axis_in  = axis_ff + AXIS_W'(1);
               state_in = ST_DOT_MUL;
            end
         end

         // A first vertex opens a new polygon.
         ST_DIST: begin
            cur_d_in = dist_sat;
            edge0_in = have_first_ff;
            edge1_in = last_ff;
            if (!have_first_ff) begin
               first_v_in    = cur_v_ff;
               first_d_in    = dist_sat;
               count_in      = '0;
               have_first_in = 1'b1;
            end
            state_in = ST_EDGE_SEL;
         end

         // Edge from the previous vertex first, then the closing edge.
         ST_EDGE_SEL: begin
            if (edge0_ff) begin
               s_v_in   = prev_v_ff;
               s_d_in   = prev_d_ff;
               e_v_in   = cur_v_ff;
               e_d_in   = cur_d_ff;
               edge0_in = 1'b0;
               state_in = ST_EDGE_TEST;
            end else if (edge1_ff) begin
               s_v_in   = cur_v_ff;
               s_d_in   = cur_d_ff;
               e_v_in   = first_v_ff;
               e_d_in   = first_d_ff;
               edge1_in = 1'b0;
               state_in = ST_EDGE_TEST;
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_EDGE_TEST: begin
            if (s_in_side) begin
               buf_in[buf_cnt_ff[BUF_IDX_W-1:0]] = '{has_vertex: 1'b1, vert: s_v_ff};
               buf_cnt_in = buf_cnt_ff + BUF_CNT_W'(1);
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            if (s_in_side != e_in_side) begin
               rem_in     = num_diff[MUL_A_W-1] ? REM_W'(-num_diff) : REM_W'(num_diff);
               den_in     = den_diff[MUL_A_W-1] ? REM_W'(-den_diff) : REM_W'(den_diff);
               t_in       = '0;
               div_cnt_in = DIV_CNT_W'(T_FRAC_BITS);
               state_in   = ST_DIV;
            end else begin
               state_in = ST_EDGE_SEL;
            end
         end

         // One quotient bit of t per cycle, most significant first.
         ST_DIV: begin
            t_in   = {t_ff[T_W-2:0], div_ge};
            rem_in = REM_W'({rem_sub, 1'b0});
            if (div_cnt_ff == '0) begin
               axis_in  = '0;
               state_in = ST_PT_MUL;
            end else begin
               div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            end
         end

         ST_PT_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_PT_ADD;
         end

         // Intersection point, one axis at a time.
         ST_PT_ADD: begin
            pt_v_in[axis_ff] = sel_s + $signed(pt_off[COORD_W-1:0]);
            if (axis_ff == AXIS_W'(NUM_AXES - 1)) begin
               buf_in[buf_cnt_ff[BUF_IDX_W-1:0]] = '{has_vertex: 1'b1, vert: pt_v_in};
               buf_cnt_in = buf_cnt_ff + BUF_CNT_W'(1);
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               state_in = ST_EDGE_SEL;
            end else begin
               axis_in  = axis_ff + AXIS_W'(1);
               state_in = ST_PT_MUL;
            end
         end

         // Close out the item; a polygon with no output still gets an end marker.
         ST_FINISH: begin
            prev_v_in = cur_v_ff;
            prev_d_in = cur_d_ff;
            if (last_ff) begin
               have_first_in = 1'b0;
               count_in      = '0;
               kept_in       = count_ff > COUNT_W'(1);
               if (buf_cnt_ff == '0) begin
                  buf_in[0]  = '{has_vertex: 1'b0, vert: '0};
                  buf_cnt_in = BUF_CNT_W'(1);
               end
               state_in = ST_SEND;
            end else if (buf_cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SEND;
            end
         end

         ST_SEND: begin
            if (rsp_ch.ready) begin
               if (send_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + BUF_IDX_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff               <= ST_IDLE;
         have_first_ff          <= 1'b0;
         count_ff               <= '0;
         buf_cnt_ff             <= '0;
         rd_idx_ff              <= '0;
         cfg_ff[CSR_NORMAL_X]   <= '0;
         cfg_ff[CSR_NORMAL_Y]   <= '0;
         cfg_ff[CSR_NORMAL_Z]   <= NORMAL_Z_RESET;
         cfg_ff[CSR_PLANE_D]    <= '0;
      end else begin
         state_ff      <= state_in;
         have_first_ff <= have_first_in;
         count_ff      <= count_in;
         buf_cnt_ff    <= buf_cnt_in;
         rd_idx_ff     <= rd_idx_in;
         if (csr_we) begin
            cfg_ff[csr_index] <= csr_wdata;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cur_v_ff   <= cur_v_in;
      last_ff    <= last_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      axis_ff    <= axis_in;
      cur_d_ff   <= cur_d_in;
      first_v_ff <= first_v_in;
      first_d_ff <= first_d_in;
      prev_v_ff  <= prev_v_in;
      prev_d_ff  <= prev_d_in;
      edge0_ff   <= edge0_in;
      edge1_ff   <= edge1_in;
      s_v_ff     <= s_v_in;
      s_d_ff     <= s_d_in;
      e_v_ff     <= e_v_in;
      e_d_ff     <= e_d_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      t_ff       <= t_in;
      div_cnt_ff <= div_cnt_in;
      pt_v_ff    <= pt_v_in;
      buf_ff     <= buf_in;
      kept_ff    <= kept_in;
   end

   // The block never takes a vertex while results are still on offer.
   `PPC_ASSERT_ALWAYS(a_no_overlap, clock, reset, !(req_ch.ready && rsp_ch.valid))
   // No item ever produces more results than the collection buffer holds.
   `PPC_ASSERT_ALWAYS(a_buf_bound, clock, reset, buf_cnt_ff <= BUF_CNT_W'(BUF_DEPTH))
   // Once the end item of a polygon is taken, the block waits for a new vertex.
   `PPC_ASSERT_NEXT(a_end_idle, clock, reset, rsp_ch.valid && rsp_ch.ready && rsp_ch.polygon_end, req_ch.ready)

endmodule
